/* hdl/psrrl_pkg.sv */
// ----------------------------------------------------------------------------
// psrrl_pkg
// Shared types and constants for the per-sender reply rate limiter.
// ----------------------------------------------------------------------------
package psrrl_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 8;
   localparam int DEFAULT_ADDRESS_BITS  = 48;

   localparam int GAP_W  = 31;
   localparam int TIME_W = 32;

   localparam logic [GAP_W-1:0] GAP_RESET = 31'd1000000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic out_free;
   } status_type;

endpackage

/* hdl/psrrl_ram.sv */
// ----------------------------------------------------------------------------
// psrrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psrrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/psrrl_ctrl.sv */
// ----------------------------------------------------------------------------
// psrrl_ctrl
// Sequencer: accept a request, scan the table, then commit and respond.
// ----------------------------------------------------------------------------
module psrrl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  psrrl_pkg::status_type  status,
   output psrrl_pkg::cmd_type     cmd,
   output logic                   req_stall
);

   import psrrl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.miss) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/psrrl_dpath.sv */
// ----------------------------------------------------------------------------
// psrrl_dpath
// Request registers, sender table, scan counters, decision and output word.
// ----------------------------------------------------------------------------
module psrrl_dpath #(
   parameter int TABLE_ENTRIES = psrrl_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int ADDRESS_BITS  = psrrl_pkg::DEFAULT_ADDRESS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ADDRESS_BITS-1:0]       req_sender_address,
   input  logic                          req_needs_reply,
   input  logic [psrrl_pkg::TIME_W-1:0]  req_now_us,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [psrrl_pkg::GAP_W-1:0]   csr_reply_gap_us,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic                          rsp_send_reply,
   input  psrrl_pkg::cmd_type            cmd,
   output psrrl_pkg::status_type         status
);

   import psrrl_pkg::*;

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int WORD_W = ADDRESS_BITS + 1 + TIME_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   // request
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic                    need_ff;
   logic [TIME_W-1:0]       now_ff;

   // table bookkeeping
   logic [CNT_W-1:0] used_ff,   used_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [GAP_W-1:0] gap_ff,    gap_in;

   // scan
   logic [CNT_W-1:0] issue_idx_ff, issue_idx_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff,   cmp_idx_in;

   // decision
   logic             reply_ff, reply_in;
   logic             wr_ff,    wr_in;
   logic             miss_ff,  miss_in;
   logic             answered_ff, answered_in;
   logic [IDX_W-1:0] slot_ff,  slot_in;

   // output word
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_reply_ff, rsp_reply_in;

   // memory ports
   logic              rd_en;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;

   logic                    full;
   logic                    issue_more;
   logic                    addr_eq;
   logic                    ent_answered;
   logic [TIME_W-1:0]       ent_time;
   logic [TIME_W-1:0]       diff;
   logic                    within_gap;
   logic                    hit_reply;

   psrrl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      full         = (used_ff == CNT_FULL);
      issue_more   = (issue_idx_ff != used_ff);
      addr_eq      = (rd_data[WORD_W-1 -: ADDRESS_BITS] == addr_ff);
      ent_answered = rd_data[TIME_W];
      ent_time     = rd_data[TIME_W-1:0];
      diff         = now_ff - ent_time;
      within_gap   = diff[TIME_W-1] | ({1'b0, diff[TIME_W-2:0]} < {1'b0, gap_ff});
      hit_reply    = need_ff & ~(ent_answered & within_gap);

      status.hit      = cmp_valid_ff & addr_eq;
      status.miss     = ~status.hit & ~issue_more;
      status.out_free = ~rsp_valid_ff | ~rsp_stall;

      rd_en   = cmd.scan & ~status.hit & issue_more;
      wr_en   = cmd.commit & wr_ff;
      wr_data = {addr_ff, answered_ff, now_ff};
   end

   always_comb begin
      used_in      = used_ff;
      oldest_in    = oldest_ff;
      gap_in       = gap_ff;
      issue_idx_in = issue_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      reply_in     = reply_ff;
      wr_in        = wr_ff;
      miss_in      = miss_ff;
      answered_in  = answered_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_reply_in = rsp_reply_ff;

      if (csr_valid && csr_ready) begin
         gap_in = csr_reply_gap_us;
      end

      if (cmd.load) begin
         issue_idx_in = '0;
      end

      // issue one table read per cycle, compare it the next
      if (rd_en) begin
         issue_idx_in = issue_idx_ff + CNT_W'(1);
         cmp_valid_in = 1'b1;
         cmp_idx_in   = issue_idx_ff[IDX_W-1:0];
      end

      if (cmd.scan && status.hit) begin
         reply_in    = hit_reply;
         wr_in       = hit_reply;
         miss_in     = 1'b0;
         answered_in = 1'b1;
         slot_in     = cmp_idx_ff;
      end else if (cmd.scan && status.miss) begin
         reply_in    = 1'b1;
         wr_in       = 1'b1;
         miss_in     = 1'b1;
         answered_in = need_ff;
         slot_in     = full ? oldest_ff : used_ff[IDX_W-1:0];
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_reply_in = reply_ff;
         if (miss_ff) begin
            if (!full) begin
               used_in = used_ff + CNT_W'(1);
            end else if (oldest_ff == IDX_LAST) begin
               oldest_in = '0;
            end else begin
               oldest_in = oldest_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         oldest_ff    <= '0;
         gap_ff       <= GAP_RESET;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         oldest_ff    <= oldest_in;
         gap_ff       <= gap_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_sender_address;
         need_ff <= req_needs_reply;
         now_ff  <= req_now_us;
      end
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      reply_ff     <= reply_in;
      wr_ff        <= wr_in;
      miss_ff      <= miss_in;
      answered_ff  <= answered_in;
      slot_ff      <= slot_in;
      rsp_reply_ff <= rsp_reply_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_reply = rsp_reply_ff;

endmodule

/* hdl/per_sender_reply_rate_limiter.sv */
// ----------------------------------------------------------------------------
// per_sender_reply_rate_limiter
// Decides per sender whether a busy reply goes out now, at most one reply per
// sender within the programmed gap, using a small FIFO-recycled sender table.
// ----------------------------------------------------------------------------
// One request is handled at a time. The table memory is read one entry per
// cycle; a scan stops at a hit, or after every used entry on a miss, and
// the next request can be accepted once the result is committed. The result
// word sits in an output register, so a new request is accepted while it
// waits. csr_reply_gap_us sets the minimum microseconds between two replies to
// one sender and may be written only while the block is idle.
module per_sender_reply_rate_limiter #(
   parameter int TABLE_ENTRIES = psrrl_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int ADDRESS_BITS  = psrrl_pkg::DEFAULT_ADDRESS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ADDRESS_BITS-1:0]       req_sender_address,
   input  logic                          req_needs_reply,
   input  logic [psrrl_pkg::TIME_W-1:0]  req_now_us,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_send_reply,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [psrrl_pkg::GAP_W-1:0]   csr_reply_gap_us
);

   import psrrl_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   psrrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   psrrl_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDRESS_BITS  (ADDRESS_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_sender_address (req_sender_address),
      .req_needs_reply    (req_needs_reply),
      .req_now_us         (req_now_us),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_reply_gap_us   (csr_reply_gap_us),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_send_reply     (rsp_send_reply),
      .cmd                (cmd),
      .status             (status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a previous one is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("result word overwritten before it was taken");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result word appeared without a commit");

endmodule

/* tb/tb_per_sender_reply_rate_limiter.sv */
// ----------------------------------------------------------------------------
// tb_per_sender_reply_rate_limiter
// Self-checking bench for the per-sender reply rate limiter. A short table of
// directed requests covers empty, hit, miss, eviction, wrapped time and gap
// boundaries. Random phases follow, each after a gap register write, and draw
// senders from a small pool so that hits and FIFO replacement are frequent.
// Both channels idle and stall at random. Every reply word is checked against
// a behavioral copy of the sender table kept in the bench, or a directed row's value.
// ----------------------------------------------------------------------------
module tb_per_sender_reply_rate_limiter;

   import psrrl_pkg::*;

   localparam int ENTRIES  = DEFAULT_TABLE_ENTRIES;
   localparam int ADDR_W   = DEFAULT_ADDRESS_BITS;
   localparam int PHASES   = 7;
   localparam int PER_PHASE = 285;
   localparam int WATCHDOG = 4000;
   localparam int PROBE_ROWS = 22;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              need;
      logic [TIME_W-1:0] stamp;
      logic              has_lit;
      logic              lit;
   } probe_row_type;

   localparam logic [ADDR_W-1:0] ONES = {ADDR_W{1'b1}};

   localparam probe_row_type PROBES [PROBE_ROWS] = '{
      '{48'h0,            1'b1, 32'd0,          1'b1, 1'b1},
      '{48'h0,            1'b1, 32'd10,         1'b1, 1'b0},
      '{48'h0,            1'b0, 32'd2000000,    1'b1, 1'b0},
      '{48'h0,            1'b1, 32'd1000000,    1'b0, 1'b0},
      '{ONES,             1'b0, 32'hFFFFFFFF,   1'b1, 1'b1},
      '{ONES,             1'b1, 32'hFFFFFFF0,   1'b0, 1'b0},
      '{ONES,             1'b1, 32'h00000005,   1'b0, 1'b0},
      '{48'h0,            1'b1, 32'd0,          1'b0, 1'b0},
      '{ONES,             1'b1, 32'h7FFFFFF0,   1'b0, 1'b0},
      '{48'h1,            1'b1, 32'd100,        1'b1, 1'b1},
      '{48'h2,            1'b0, 32'd100,        1'b1, 1'b1},
      '{48'h800000000000, 1'b1, 32'd100,        1'b1, 1'b1},
      '{48'h555555555555, 1'b0, 32'd100,        1'b1, 1'b1},
      '{48'hAAAAAAAAAAAA, 1'b1, 32'd100,        1'b1, 1'b1},
      '{48'h3,            1'b0, 32'd100,        1'b1, 1'b1},
      '{48'h4,            1'b1, 32'd100,        1'b1, 1'b1},
      '{48'h0,            1'b1, 32'd101,        1'b1, 1'b1},
      '{ONES,             1'b0, 32'd102,        1'b1, 1'b1},
      '{48'h555555555555, 1'b1, 32'd200,        1'b0, 1'b0},
      '{48'h555555555555, 1'b1, 32'd201,        1'b0, 1'b0},
      '{48'hAAAAAAAAAAAA, 1'b1, 32'd1000100,    1'b0, 1'b0},
      '{48'h1,            1'b0, 32'hFFFFFFFF,   1'b0, 1'b0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ADDR_W-1:0] req_sender_address = '0;
   logic              req_needs_reply = 1'b0;
   logic [TIME_W-1:0] req_now_us = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_send_reply;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [GAP_W-1:0]  csr_reply_gap_us = '0;

   logic [ADDR_W-1:0] seen_addr [ENTRIES];
   logic              seen_answered [ENTRIES];
   logic [TIME_W-1:0] seen_time [ENTRIES];
   int unsigned       seen_count = 0;
   int unsigned       evict_ptr = 0;
   logic [GAP_W-1:0]  gap_us = GAP_RESET;

   logic              reply_due_q [$];
   int unsigned       mismatches = 0;
   int unsigned       replies_seen = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       stall_left = 0;
   bit                calm_req = 1'b0;
   bit                calm_rsp = 1'b0;

   per_sender_reply_rate_limiter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sender_address (req_sender_address),
      .req_needs_reply    (req_needs_reply),
      .req_now_us         (req_now_us),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_send_reply     (rsp_send_reply),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_reply_gap_us   (csr_reply_gap_us)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned pick_pause(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic decide_busy_reply(input logic [ADDR_W-1:0] a,
                                              input logic nr,
                                              input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] diff;
      int unsigned       k;
      int unsigned       slot;
      for (k = 0; k < seen_count; k++) begin
         if (seen_addr[k] == a) begin
            if (!nr)
               return 1'b0;
            diff = stamp - seen_time[k];
            if (seen_answered[k] && (diff[TIME_W-1] || diff < {1'b0, gap_us}))
               return 1'b0;
            seen_answered[k] = 1'b1;
            seen_time[k] = stamp;
            return 1'b1;
         end
      end
      if (seen_count < ENTRIES) begin
         slot = seen_count;
         seen_count++;
      end else begin
         slot = evict_ptr;
         evict_ptr = (evict_ptr + 1) % ENTRIES;
      end
      seen_addr[slot] = a;
      seen_answered[slot] = nr;
      seen_time[slot] = stamp;
      return 1'b1;
   endfunction

   task automatic offer_request(input logic [ADDR_W-1:0] a, input logic nr,
                                input logic [TIME_W-1:0] stamp,
                                input logic has_lit, input logic lit);
      int unsigned pause;
      logic        want;
      pause = pick_pause(calm_req);
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sender_address <= a;
      req_needs_reply <= nr;
      req_now_us <= stamp;
      do @(posedge clock); while (req_stall);
      want = decide_busy_reply(a, nr, stamp);
      if (has_lit)
         want = lit;
      reply_due_q.push_back(want);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (reply_due_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_gap(input logic [GAP_W-1:0] v);
      csr_valid <= 1'b1;
      csr_reply_gap_us <= v;
      do @(posedge clock); while (!csr_ready);
      gap_us = v;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0)
         calm_rsp <= !calm_rsp;
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 2) == 0)
            stall_left <= pick_pause(calm_rsp);
      end
   end

   always @(posedge clock) begin : check_replies
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply word, send_reply %0b", rsp_send_reply);
         end else begin
            want = reply_due_q.pop_front();
            if (rsp_send_reply !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reply %0d: send_reply expected %0b actual %0b",
                           replies_seen, want, rsp_send_reply);
            end
            replies_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [GAP_W-1:0]  gaps [PHASES];
      logic [ADDR_W-1:0] pool [16];
      logic [ADDR_W-1:0] a;
      logic [TIME_W-1:0] cursor;
      logic [TIME_W-1:0] step;
      logic [TIME_W-1:0] gv;
      int unsigned       p;
      int unsigned       n;
      int unsigned       k;
      int unsigned       psz;

      gaps = '{31'd0, 31'h7FFFFFFF, 31'd1, 31'd37, 31'd5000, GAP_RESET,
               31'($urandom_range(0, 200000))};
      cursor = $urandom;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < PROBE_ROWS; n++)
         offer_request(PROBES[n].addr, PROBES[n].need, PROBES[n].stamp,
                       PROBES[n].has_lit, PROBES[n].lit);

      for (p = 0; p < PHASES; p++) begin
         drain_replies();
         write_gap(gaps[p]);
         gv = {1'b0, gap_us};
         psz = $urandom_range(2, 14);
         for (k = 0; k < 16; k++)
            pool[k] = {16'($urandom), $urandom};
         case ($urandom_range(0, 2))
            0: cursor = $urandom;
            1: cursor = 32'hFFFFFFFF - $urandom_range(0, 5000);
            default: cursor = cursor;
         endcase
         for (n = 0; n < PER_PHASE; n++) begin
            if ($urandom_range(0, 149) == 0)
               calm_req = !calm_req;
            case ($urandom_range(0, 9))
               0: step = '0;
               1, 2, 3: step = $urandom_range(0, 16);
               4, 5: step = $urandom_range(0, gv / 2);
               6: step = gv - $urandom_range(0, 2);
               7: step = gv + $urandom_range(0, 2);
               8: step = 32'd0 - $urandom_range(1, 50);
               default: step = $urandom;
            endcase
            cursor = cursor + step;
            if ($urandom_range(0, 9) == 0)
               a = {16'($urandom), $urandom};
            else
               a = pool[$urandom_range(0, psz - 1)];
            offer_request(a, $urandom_range(0, 4) != 0, cursor, 1'b0, 1'b0);
         end
      end

      drain_replies();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && reply_due_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
hdl/psrrl_pkg.sv
hdl/psrrl_ram.sv
hdl/psrrl_ctrl.sv
hdl/psrrl_dpath.sv
hdl/per_sender_reply_rate_limiter.sv
tb/tb_per_sender_reply_rate_limiter.sv
